>>> rtl/mcbp_pkg.sv
package mcbp_pkg;

    // default configuration
    localparam int DEF_NUM_PIPES  = 32;
    localparam int DEF_PIPE_DEPTH = 4096;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int ID_W   = 5;
    localparam int BYTE_W = 8;
    localparam int XFER_W = 13;
    localparam int STAT_W = 2;

    // per-request transfer count saturates here
    localparam int TRANSFER_CAP = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_CLOSE  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_STOP = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec_rw;
        logic exec_scan;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic is_create;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/mcbp_req_if.sv
interface mcbp_req_if;
    logic                        valid;
    logic                        ready;
    logic [mcbp_pkg::OP_W-1:0]   operation;
    logic [mcbp_pkg::ID_W-1:0]   pipe_id;
    logic [mcbp_pkg::BYTE_W-1:0] data_in;
    logic                        last_of_request;

    modport source (output valid, output operation, output pipe_id, output data_in,
                    output last_of_request, input ready);
    modport sink (input valid, input operation, input pipe_id, input data_in,
                  input last_of_request, output ready);
endinterface

>>> rtl/mcbp_rsp_if.sv
interface mcbp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mcbp_pkg::STAT_W-1:0] status;
    logic [mcbp_pkg::BYTE_W-1:0] data_out;
    logic [mcbp_pkg::ID_W-1:0]   new_pipe;
    logic [mcbp_pkg::XFER_W-1:0] transferred;
    logic                        request_done;

    modport source (output valid, output status, output data_out, output new_pipe,
                    output transferred, output request_done, input ready);
    modport sink (input valid, input status, input data_out, input new_pipe,
                  input transferred, input request_done, output ready);
endinterface

>>> rtl/multi_channel_byte_pipe_unit.sv
// sequencing: each item is latched, executed and its result loaded into the output register;
// a new item is taken only after the result of the last one is in the output register, which
// waits while the output still holds an unaccepted result; a create checks one pipe per cycle,
// lowest first, until it finds a free pipe or reaches the last pipe
// reset: all pipes inactive, request count and stop mark cleared, output empty;
// byte store and pointer memory are not cleared, no clearing pass
module multi_channel_byte_pipe_unit #(
    parameter int NUM_PIPES  = mcbp_pkg::DEF_NUM_PIPES,
    parameter int PIPE_DEPTH = mcbp_pkg::DEF_PIPE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    mcbp_req_if.sink    req,
    mcbp_rsp_if.source  rsp
);

    mcbp_pkg::cmd_t  cmd;
    mcbp_pkg::stat_t st;

    // sequencer
    mcbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // pipe state, byte store and output register
    mcbp_datapath #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .st    (st)
    );

endmodule

>>> rtl/mcbp_ram.sv
module mcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/mcbp_ctrl.sv
module mcbp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  mcbp_pkg::stat_t st,
    output mcbp_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencing of one item
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (st.in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.is_create)
                begin
                    cmd.exec_scan = 1'b1;
                    if (st.scan_done)
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    cmd.exec_rw = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mcbp_datapath.sv
module mcbp_datapath #(
    parameter int NUM_PIPES  = mcbp_pkg::DEF_NUM_PIPES,
    parameter int PIPE_DEPTH = mcbp_pkg::DEF_PIPE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    mcbp_req_if.sink         req,
    mcbp_rsp_if.source       rsp,
    input  mcbp_pkg::cmd_t   cmd,
    output mcbp_pkg::stat_t  st
);

    localparam int ID_W    = mcbp_pkg::ID_W;
    localparam int BYTE_W  = mcbp_pkg::BYTE_W;
    localparam int XFER_W  = mcbp_pkg::XFER_W;
    localparam int IDX_W   = $clog2(NUM_PIPES);
    localparam int WIDE_W  = ID_W + IDX_W;
    localparam int PTR_W   = $clog2(PIPE_DEPTH);
    localparam int CNT_W   = $clog2(PIPE_DEPTH + 1);
    localparam int ENT_W   = 2 * PTR_W + CNT_W;
    localparam int STORE_D = NUM_PIPES * PIPE_DEPTH;
    localparam int BADDR_W = $clog2(STORE_D);

    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(PIPE_DEPTH - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(PIPE_DEPTH);
    localparam logic [BADDR_W-1:0] DEPTH_B  = BADDR_W'(PIPE_DEPTH);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(NUM_PIPES - 1);
    localparam logic [WIDE_W-1:0]  NUM_W    = WIDE_W'(NUM_PIPES);
    localparam logic [XFER_W-1:0]  CAP      = XFER_W'(mcbp_pkg::TRANSFER_CAP);

    // latched item
    mcbp_pkg::op_t        op_reg, op_next;
    logic [BYTE_W-1:0]    din_reg, din_next;
    logic                 last_reg, last_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 id_ok_reg, id_ok_next;
    logic [BADDR_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;

    // pipe and request state
    logic [NUM_PIPES-1:0] active_reg, active_next;
    logic [XFER_W-1:0]    moved_reg, moved_next;
    logic                 stopped_reg, stopped_next;

    // result of the current item
    mcbp_pkg::status_t    res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_npipe_reg, res_npipe_next;
    logic [XFER_W-1:0]    res_moved_reg, res_moved_next;
    logic                 rd_ok_reg, rd_ok_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    mcbp_pkg::status_t    out_status_reg, out_status_next;
    logic [BYTE_W-1:0]    out_data_reg, out_data_next;
    logic [ID_W-1:0]      out_npipe_reg, out_npipe_next;
    logic [XFER_W-1:0]    out_moved_reg, out_moved_next;
    logic                 out_done_reg, out_done_next;

    // memory ports
    logic                 st_we;
    logic [IDX_W-1:0]     st_waddr;
    logic [ENT_W-1:0]     st_wdata;
    logic [ENT_W-1:0]     st_rdata;
    logic                 bs_we;
    logic                 bs_re;
    logic [BADDR_W-1:0]   bs_waddr;
    logic [BADDR_W-1:0]   bs_raddr;
    logic [BYTE_W-1:0]    bs_rdata;

    // helpers
    logic                 accept;
    logic [WIDE_W-1:0]    req_wide;
    logic [IDX_W-1:0]     req_idx;
    logic [WIDE_W-1:0]    scan_wide;
    logic                 scan_free;
    logic                 scan_last;
    logic [PTR_W-1:0]     ent_rd, ent_wr, rd_adv, wr_adv;
    logic [CNT_W-1:0]     ent_cnt;
    logic                 hit;
    logic [XFER_W-1:0]    moved_inc;
    logic [XFER_W-1:0]    moved_calc;
    logic                 stop_calc;

    assign accept   = cmd.take & req.valid;
    assign req.ready = cmd.take;

    assign req_wide  = {IDX_W'(0), req.pipe_id};
    assign req_idx   = req_wide[IDX_W-1:0];
    assign scan_wide = {ID_W'(0), scan_reg};
    assign scan_free = ~active_reg[scan_reg];
    assign scan_last = (scan_reg == IDX_LAST);

    // pointer state entry: read, write pointer and fill count
    assign ent_rd  = st_rdata[ENT_W-1 -: PTR_W];
    assign ent_wr  = st_rdata[CNT_W +: PTR_W];
    assign ent_cnt = st_rdata[CNT_W-1:0];
    assign rd_adv  = (ent_rd == PTR_LAST) ? '0 : ent_rd + PTR_W'(1);
    assign wr_adv  = (ent_wr == PTR_LAST) ? '0 : ent_wr + PTR_W'(1);
    assign hit     = id_ok_reg & active_reg[idx_reg];
    assign moved_inc = (moved_reg < CAP) ? moved_reg + XFER_W'(1) : moved_reg;

    assign bs_waddr = base_reg + BADDR_W'(ent_wr);
    assign bs_raddr = base_reg + BADDR_W'(ent_rd);

    // status to the controller
    assign st.in_valid  = req.valid;
    assign st.is_create = (op_reg == mcbp_pkg::OP_CREATE);
    assign st.scan_done = scan_free | scan_last;
    assign st.out_free  = ~out_valid_reg | rsp.ready;

    // next-state logic
    always_comb
    begin
        op_next         = op_reg;
        din_next        = din_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        id_ok_next      = id_ok_reg;
        base_next       = base_reg;
        scan_next       = scan_reg;
        active_next     = active_reg;
        moved_next      = moved_reg;
        stopped_next    = stopped_reg;
        res_status_next = res_status_reg;
        res_npipe_next  = res_npipe_reg;
        res_moved_next  = res_moved_reg;
        rd_ok_next      = rd_ok_reg;
        moved_calc      = moved_reg;
        stop_calc       = stopped_reg;
        st_we           = 1'b0;
        st_waddr        = idx_reg;
        st_wdata        = '0;
        bs_we           = 1'b0;
        bs_re           = 1'b0;

        // latch item, precompute store base
        if (accept)
        begin
            op_next    = mcbp_pkg::op_t'(req.operation);
            din_next   = req.data_in;
            last_next  = req.last_of_request;
            idx_next   = req_idx;
            id_ok_next = (req_wide < NUM_W);
            base_next  = BADDR_W'(BADDR_W'(req_idx) * DEPTH_B);
            scan_next  = '0;
        end

        // read, write or close
        if (cmd.exec_rw)
        begin
            res_status_next = mcbp_pkg::STATUS_OK;
            res_npipe_next  = '0;
            res_moved_next  = '0;
            rd_ok_next      = 1'b0;
            if (op_reg == mcbp_pkg::OP_CLOSE)
            begin
                if (id_ok_reg)
                begin
                    active_next[idx_reg] = 1'b0;
                end
                else
                begin
                    res_status_next = mcbp_pkg::STATUS_NONE;
                end
            end
            else
            begin
                if (!hit)
                begin
                    res_status_next = mcbp_pkg::STATUS_NONE;
                end
                else if (stopped_reg)
                begin
                    res_status_next = mcbp_pkg::STATUS_STOP;
                end
                else if (op_reg == mcbp_pkg::OP_WRITE)
                begin
                    if (ent_cnt == CNT_FULL)
                    begin
                        res_status_next = mcbp_pkg::STATUS_STOP;
                        stop_calc       = 1'b1;
                    end
                    else
                    begin
                        bs_we      = 1'b1;
                        st_we      = 1'b1;
                        st_wdata   = {ent_rd, wr_adv, ent_cnt + CNT_W'(1)};
                        moved_calc = moved_inc;
                    end
                end
                else
                begin
                    if (ent_cnt == '0)
                    begin
                        res_status_next = mcbp_pkg::STATUS_STOP;
                        stop_calc       = 1'b1;
                    end
                    else
                    begin
                        bs_re      = 1'b1;
                        rd_ok_next = 1'b1;
                        st_we      = 1'b1;
                        st_wdata   = {rd_adv, ent_wr, ent_cnt - CNT_W'(1)};
                        moved_calc = moved_inc;
                    end
                end
                res_moved_next = moved_calc;
                // end of request clears the count and stop mark
                if (last_reg)
                begin
                    moved_next   = '0;
                    stopped_next = 1'b0;
                end
                else
                begin
                    moved_next   = moved_calc;
                    stopped_next = stop_calc;
                end
            end
        end

        // create: one pipe checked per cycle, lowest first
        if (cmd.exec_scan)
        begin
            res_moved_next = '0;
            rd_ok_next     = 1'b0;
            if (scan_free)
            begin
                active_next[scan_reg] = 1'b1;
                st_we           = 1'b1;
                st_waddr        = scan_reg;
                st_wdata        = '0;
                res_status_next = mcbp_pkg::STATUS_OK;
                res_npipe_next  = scan_wide[ID_W-1:0];
            end
            else if (scan_last)
            begin
                res_status_next = mcbp_pkg::STATUS_NONE;
                res_npipe_next  = '0;
            end
            else
            begin
                scan_next = scan_reg + IDX_W'(1);
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_npipe_next  = out_npipe_reg;
        out_moved_next  = out_moved_reg;
        out_done_next   = out_done_reg;
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_data_next   = rd_ok_reg ? bs_rdata : '0;
            out_npipe_next  = res_npipe_reg;
            out_moved_next  = res_moved_reg;
            out_done_next   = last_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.data_out     = out_data_reg;
    assign rsp.new_pipe     = out_npipe_reg;
    assign rsp.transferred  = out_moved_reg;
    assign rsp.request_done = out_done_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            moved_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            moved_reg     <= moved_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        din_reg        <= din_next;
        last_reg       <= last_next;
        idx_reg        <= idx_next;
        id_ok_reg      <= id_ok_next;
        base_reg       <= base_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_npipe_reg  <= res_npipe_next;
        res_moved_reg  <= res_moved_next;
        rd_ok_reg      <= rd_ok_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_npipe_reg  <= out_npipe_next;
        out_moved_reg  <= out_moved_next;
        out_done_reg   <= out_done_next;
    end

    // per-pipe pointers and fill count, read at accept
    mcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PIPES)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (accept),
        .raddr (req_idx),
        .rdata (st_rdata)
    );

    // byte store of all pipes
    mcbp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_D)
    ) u_byte_ram (
        .clk   (clk),
        .we    (bs_we),
        .waddr (bs_waddr),
        .wdata (din_reg),
        .re    (bs_re),
        .raddr (bs_raddr),
        .rdata (bs_rdata)
    );

endmodule
